FILE: src/imufs_pkg.sv
package imufs_pkg;

  localparam int PAYLOAD_BYTES = 20;
  localparam int MAX_WORDS     = 10;
  localparam int NUM_WORDS     = ((PAYLOAD_BYTES / 2) > MAX_WORDS) ? MAX_WORDS
                                                                   : (PAYLOAD_BYTES / 2);
  localparam int POS_W         = $clog2(PAYLOAD_BYTES);
  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int IDX_W         = 4;
  localparam int COUNT_W       = 16;
  localparam int CFG_IDX_W     = 1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h7F;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h80;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_DATA,
    PH_CHECK,
    PH_EMIT
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic pair;
  } shift_ctl_t;

endpackage

FILE: src/imufs_cell.sv
module imufs_cell (
  input  logic                           clk,
  input  imufs_pkg::shift_ctl_t          ctl,
  input  logic [imufs_pkg::BYTE_W-1:0]   near_byte,
  input  logic [imufs_pkg::BYTE_W-1:0]   far_byte,
  output logic [imufs_pkg::BYTE_W-1:0]   data
);

  // A payload byte moves one cell down as the next byte arrives, and two
  // cells down as each word leaves from the head of the row.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= near_byte;
    end else if (ctl.pair) begin
      data <= far_byte;
    end
  end

endmodule

FILE: src/imu_frame_sync_checksum_parser_core.sv
// Byte-stream frame parser: each input word is one received byte. The block
// hunts at every byte offset for the two header bytes (sync_first, then
// sync_second), shifts the payload bytes into a row of byte cells while it
// sums them, and compares the checksum byte with the inverted 8-bit sum. A
// good frame leaves the row as signed little-endian 16-bit words, one per
// cycle while out_stall is low, each with its index, a last-word mark and
// the wrapping count of good frames. A bad frame produces nothing. Outside
// the emit phase a byte is taken whenever in_valid is high; after a good
// checksum the input is stalled while the words drain, because the cell
// row shifts two bytes toward its head for each word sent. The header
// registers are written through the cfg port, which is always ready.
module imu_frame_sync_checksum_parser_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [imufs_pkg::BYTE_W-1:0]        rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [imufs_pkg::IDX_W-1:0]         word_index,
  output logic signed [imufs_pkg::WORD_W-1:0] word_value,
  output logic                                last_word,
  output logic [imufs_pkg::COUNT_W-1:0]       good_frames,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imufs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imufs_pkg::BYTE_W-1:0]        cfg_data
);

  localparam int N = imufs_pkg::PAYLOAD_BYTES;

  imufs_pkg::phase_t                  phase;
  imufs_pkg::phase_t                  phase_next;
  logic [imufs_pkg::BYTE_W-1:0]       sync_first;
  logic [imufs_pkg::BYTE_W-1:0]       sync_second;
  logic [imufs_pkg::POS_W-1:0]        position;
  logic [imufs_pkg::BYTE_W-1:0]       running_sum;
  logic [imufs_pkg::COUNT_W-1:0]      frame_counter;
  logic [imufs_pkg::IDX_W-1:0]        word_count;
  logic [imufs_pkg::BYTE_W-1:0]       cell_data [N];
  imufs_pkg::shift_ctl_t              shift_ctl;
  logic                               in_accept;
  logic                               out_free;
  logic                               emit_load;
  logic                               frame_good;
  logic                               sum_match;
  logic                               last_pos;
  logic                               last_emit;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign sum_match = (~running_sum == rx_byte);
  assign last_pos  = (position == imufs_pkg::POS_W'(N - 1));
  assign last_emit = (word_count == imufs_pkg::IDX_W'(imufs_pkg::NUM_WORDS - 1));

  always_comb begin
    phase_next = phase;
    unique case (phase)
      imufs_pkg::PH_HUNT1: begin
        if (in_accept && rx_byte == sync_first) begin
          phase_next = imufs_pkg::PH_HUNT2;
        end
      end
      imufs_pkg::PH_HUNT2: begin
        if (in_accept) begin
          priority if (rx_byte == sync_second) begin
            phase_next = imufs_pkg::PH_DATA;
          end else if (rx_byte == sync_first) begin
            phase_next = imufs_pkg::PH_HUNT2;
          end else begin
            phase_next = imufs_pkg::PH_HUNT1;
          end
        end
      end
      imufs_pkg::PH_DATA: begin
        if (in_accept && last_pos) begin
          phase_next = imufs_pkg::PH_CHECK;
        end
      end
      imufs_pkg::PH_CHECK: begin
        if (in_accept) begin
          phase_next = sum_match ? imufs_pkg::PH_EMIT : imufs_pkg::PH_HUNT1;
        end
      end
      imufs_pkg::PH_EMIT: begin
        if (out_free && last_emit) begin
          phase_next = imufs_pkg::PH_HUNT1;
        end
      end
      default: phase_next = imufs_pkg::PH_HUNT1;
    endcase
  end

  always_comb begin
    in_stall       = (phase == imufs_pkg::PH_EMIT);
    emit_load      = (phase == imufs_pkg::PH_EMIT) && out_free;
    frame_good     = (phase == imufs_pkg::PH_CHECK) && in_accept && sum_match;
    shift_ctl.load = (phase == imufs_pkg::PH_DATA) && in_accept;
    shift_ctl.pair = emit_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= imufs_pkg::PH_HUNT1;
      sync_first    <= imufs_pkg::SYNC_FIRST_RESET;
      sync_second   <= imufs_pkg::SYNC_SECOND_RESET;
      position      <= '0;
      running_sum   <= '0;
      frame_counter <= '0;
      word_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_valid && cfg_ready) begin
        unique case (imufs_pkg::cfg_reg_t'(cfg_index))
          imufs_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_data;
          imufs_pkg::REG_SYNC_SECOND: sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (phase == imufs_pkg::PH_HUNT2) begin
        position    <= '0;
        running_sum <= '0;
      end else if (shift_ctl.load) begin
        position    <= position + imufs_pkg::POS_W'(1);
        running_sum <= running_sum + rx_byte;
      end
      if (frame_good) begin
        frame_counter <= frame_counter + imufs_pkg::COUNT_W'(1);
        word_count    <= '0;
      end else if (emit_load) begin
        word_count <= word_count + imufs_pkg::IDX_W'(1);
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      word_index  <= word_count;
      word_value  <= {cell_data[1], cell_data[0]};
      last_word   <= last_emit;
      good_frames <= frame_counter;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [imufs_pkg::BYTE_W-1:0] near_byte;
    logic [imufs_pkg::BYTE_W-1:0] far_byte;
    if (i == N - 1) begin : g_tail
      assign near_byte = rx_byte;
    end else begin : g_body
      assign near_byte = cell_data[i + 1];
    end
    if (i + 2 < N) begin : g_far
      assign far_byte = cell_data[i + 2];
    end else begin : g_far_end
      assign far_byte = '0;
    end
    imufs_cell u_cell (
      .clk       (clk),
      .ctl       (shift_ctl),
      .near_byte (near_byte),
      .far_byte  (far_byte),
      .data      (cell_data[i])
    );
  end

`ifndef SYNTHESIS
  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(phase) == imufs_pkg::PH_EMIT)
    else $error("result word appeared outside the emit phase");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_word) |->
      word_index == imufs_pkg::IDX_W'(imufs_pkg::NUM_WORDS - 1))
    else $error("last word mark on the wrong word index");

  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_word) |-> phase == imufs_pkg::PH_EMIT)
    else $error("frame emission ended before its last word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (phase == imufs_pkg::PH_CHECK && in_accept && sum_match) |=>
      frame_counter == $past(frame_counter) + imufs_pkg::COUNT_W'(1))
    else $error("good frame count did not advance");
`endif

endmodule

FILE: dv/tb_imu_frame_sync_checksum_parser_core.sv
module tb_imu_frame_sync_checksum_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [imufs_pkg::BYTE_W-1:0] rx_byte_t;

  typedef struct {
    logic [imufs_pkg::IDX_W-1:0]   index;
    logic [imufs_pkg::WORD_W-1:0]  value;
    logic                          last;
    logic [imufs_pkg::COUNT_W-1:0] count;
  } imu_word_t;

  class frame_scoreboard;
    rx_byte_t                      sync_first;
    rx_byte_t                      sync_second;
    imufs_pkg::phase_t             phase;
    int unsigned                   byte_pos;
    rx_byte_t                      payload_bytes [imufs_pkg::PAYLOAD_BYTES];
    rx_byte_t                      payload_sum;
    logic [imufs_pkg::COUNT_W-1:0] frame_count;
    imu_word_t                     pending_words [$];
    int                            errors;
    int                            bytes_seen;
    int                            words_checked;
    int                            frames_seen;

    function new();
      sync_first    = imufs_pkg::SYNC_FIRST_RESET;
      sync_second   = imufs_pkg::SYNC_SECOND_RESET;
      phase         = imufs_pkg::PH_HUNT1;
      byte_pos      = 0;
      payload_sum   = '0;
      frame_count   = '0;
      errors        = 0;
      bytes_seen    = 0;
      words_checked = 0;
      frames_seen   = 0;
      foreach (payload_bytes[i]) payload_bytes[i] = '0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_config(input imufs_pkg::cfg_reg_t idx, input rx_byte_t data);
      case (idx)
        imufs_pkg::REG_SYNC_FIRST:  sync_first = data;
        imufs_pkg::REG_SYNC_SECOND: sync_second = data;
        default: ;
      endcase
    endfunction

    function void note_byte(input rx_byte_t b);
      imu_word_t w;
      bytes_seen++;
      case (phase)
        imufs_pkg::PH_HUNT1: begin
          if (b == sync_first) phase = imufs_pkg::PH_HUNT2;
        end
        imufs_pkg::PH_HUNT2: begin
          if (b == sync_second) begin
            phase       = imufs_pkg::PH_DATA;
            byte_pos    = 0;
            payload_sum = '0;
          end else if (b != sync_first) begin
            phase = imufs_pkg::PH_HUNT1;
          end
        end
        imufs_pkg::PH_DATA: begin
          payload_bytes[byte_pos] = b;
          payload_sum = payload_sum + b;
          byte_pos++;
          if (byte_pos >= imufs_pkg::PAYLOAD_BYTES) phase = imufs_pkg::PH_CHECK;
        end
        default: begin
          if (rx_byte_t'(~payload_sum) == b) begin
            frame_count = frame_count + 1'b1;
            frames_seen++;
            for (int k = 0; k < imufs_pkg::NUM_WORDS; k++) begin
              w.index = k[imufs_pkg::IDX_W-1:0];
              w.value = {payload_bytes[2*k+1], payload_bytes[2*k]};
              w.last  = (k == imufs_pkg::NUM_WORDS - 1);
              w.count = frame_count;
              pending_words.push_back(w);
            end
          end
          phase       = imufs_pkg::PH_HUNT1;
          byte_pos    = 0;
          payload_sum = '0;
        end
      endcase
    endfunction

    task check_word(input logic [imufs_pkg::IDX_W-1:0] index,
                    input logic [imufs_pkg::WORD_W-1:0] value,
                    input logic last,
                    input logic [imufs_pkg::COUNT_W-1:0] count);
      imu_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word index %0d value %h", index, value));
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (index !== w.index)
          report($sformatf("word_index got %0d want %0d", index, w.index));
        if (value !== w.value)
          report($sformatf("word_value got %h want %h (index %0d)", value, w.value, w.index));
        if (last !== w.last)
          report($sformatf("last_word got %b want %b (index %0d)", last, w.last, w.index));
        if (count !== w.count)
          report($sformatf("good_frames got %0d want %0d", count, w.count));
      end
    endtask
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  rx_byte_t                             rx_byte = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [imufs_pkg::IDX_W-1:0]          word_index;
  logic signed [imufs_pkg::WORD_W-1:0]  word_value;
  logic                                 last_word;
  logic [imufs_pkg::COUNT_W-1:0]        good_frames;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  imufs_pkg::cfg_reg_t                  cfg_index = imufs_pkg::REG_SYNC_FIRST;
  rx_byte_t                             cfg_data = '0;

  frame_scoreboard sb;
  int              idle_pct;
  int              stall_pct;
  int              sent_bytes;

  imu_frame_sync_checksum_parser_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word_index  (word_index),
    .word_value  (word_value),
    .last_word   (last_word),
    .good_frames (good_frames),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_byte(rx_byte);
      if (out_valid && !out_stall)
        sb.check_word(word_index, word_value, last_word, good_frames);
    end
  end

  task automatic send_byte(input rx_byte_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic write_headers(input rx_byte_t first, input rx_byte_t second);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? imufs_pkg::REG_SYNC_FIRST : imufs_pkg::REG_SYNC_SECOND;
      cfg_data  <= (i == 0) ? first : second;
      @(posedge clk);
      while (!(cfg_valid && cfg_ready)) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input bit corrupt);
    rx_byte_t b;
    rx_byte_t sum;
    int       extra;
    extra = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (extra) send_byte(sb.sync_first);
    send_byte(sb.sync_first);
    send_byte(sb.sync_second);
    sum = '0;
    for (int i = 0; i < imufs_pkg::PAYLOAD_BYTES; i++) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = rx_byte_t'($urandom);
      endcase
      sum = sum + b;
      send_byte(b);
    end
    if (corrupt) send_byte(~sum ^ rx_byte_t'($urandom_range(1, 255)));
    else send_byte(~sum);
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = sent_bytes + count;
    while (sent_bytes < target) begin
      pick = $urandom_range(9);
      if (pick <= 5) begin
        send_frame($urandom_range(4) == 0);
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 4)) send_byte(rx_byte_t'($urandom));
      end else begin
        send_byte(sb.sync_first);
        send_byte(rx_byte_t'($urandom));
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic send_directed();
    rx_byte_t payload [imufs_pkg::PAYLOAD_BYTES] = '{
      8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00,
      8'h00, 8'h01, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h7F, 8'h80
    };
    rx_byte_t sum;
    sum = '0;
    send_byte(imufs_pkg::SYNC_FIRST_RESET);
    send_byte(imufs_pkg::SYNC_FIRST_RESET);
    send_byte(imufs_pkg::SYNC_SECOND_RESET);
    foreach (payload[i]) begin
      sum = sum + payload[i];
      send_byte(payload[i]);
    end
    send_byte(~sum);
    send_byte(imufs_pkg::SYNC_SECOND_RESET);
    in_valid <= 1'b0;
  endtask

  initial begin
    sb         = new();
    idle_pct   = 27;
    stall_pct  = 73;
    sent_bytes = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed();
    settle();
    run_random(100);
    settle();
    write_headers(8'hFF, 8'h00);
    run_random(60);

    idle_pct  = 73;
    stall_pct = 27;
    settle();
    write_headers(8'h00, 8'hFF);
    run_random(80);
    settle();
    write_headers(8'h3C, 8'h3C);
    run_random(60);

    idle_pct  = 0;
    stall_pct = 0;
    settle();
    write_headers(rx_byte_t'($urandom), rx_byte_t'($urandom));
    run_random(80);
    settle();
    write_headers(imufs_pkg::SYNC_FIRST_RESET, imufs_pkg::SYNC_SECOND_RESET);
    run_random(40);

    settle();
    if (sb.pending_words.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));
    $display("Run covered %0d bytes across six header settings and three idle patterns.",
             sb.bytes_seen);
    $display("It checked %0d words from %0d good frames; %0d mismatches.",
             sb.words_checked, sb.frames_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout: the run did not finish in time.");
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
src/imufs_pkg.sv
src/imufs_cell.sv
src/imu_frame_sync_checksum_parser_core.sv
dv/tb_imu_frame_sync_checksum_parser_core.sv
